// File: hdl/ice_pkg.sv
// Shared types, constants and helpers for the inline command extractor.
// Used by ice_ctrl, ice_datapath and inline_command_extractor_core.
package ice_pkg;

    localparam int PAYLOAD_DEPTH = 32;
    localparam int MARKER_MAX    = 8;

    localparam int MARKER_W   = 64;
    localparam int LEN_W      = 4;
    localparam int MC_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = $clog2(PAYLOAD_DEPTH + 1);
    localparam int ADDR_W     = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int IDX_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int PEND_CNT_W = $clog2(MARKER_MAX + 1);
    localparam int PEND_IDX_W = (MARKER_MAX > 1) ? $clog2(MARKER_MAX) : 1;

    localparam logic [CFG_IDX_W-1:0] REG_OPEN_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_MARKER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LENGTH = 2'd3;

    typedef enum logic [1:0] {
        MODE_TEXT    = 2'd0,
        MODE_OPEN    = 2'd1,
        MODE_PAYLOAD = 2'd2,
        MODE_CLOSE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    // where an emitted byte comes from
    typedef enum logic [1:0] {
        SRC_NONE       = 2'd0,
        SRC_OPEN_LANE  = 2'd1,
        SRC_CLOSE_LANE = 2'd2,
        SRC_PAYLOAD    = 2'd3
    } src_t;

    typedef struct packed {
        logic  load;      // take a feed request into the rescan queue
        logic  snap;      // capture payload count/overflow, clear index
        logic  step;      // run one parser step on the queue head
        logic  emit;      // push one result from emit_src
        kind_t emit_kind;
        src_t  emit_src;
        logic  idx_clr;
        logic  idx_inc;
        logic  mem_rd;    // read payload buffer at index
        logic  finish;    // release staged result with last set
        logic  clear;     // return parser to text mode
    } dp_cmd_t;

    typedef struct packed {
        logic                in_flush;
        logic                can_emit;
        logic                out_free;
        logic                stage_valid;
        logic                npend_zero;
        logic                step_cmd;   // current step completes a command
        logic                pay_empty;
        mode_t               mode;
        logic [MC_W-1:0]     mc;
        logic [LEN_W-1:0]    olen;
        logic [CNT_W-1:0]    snap_cnt;
        logic [IDX_W-1:0]    idx;
    } dp_stat_t;

    // marker length as used: 0 acts as 1, clamp at MARKER_MAX
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (v > LEN_W'(MARKER_MAX))
            r = LEN_W'(MARKER_MAX);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [7:0] lane(input logic [MARKER_W-1:0] m, input logic [2:0] i);
        return m[{i, 3'b000} +: 8];
    endfunction

endpackage

// File: hdl/ice_ctrl.sv
// Sequencer for the inline command extractor: accepts requests, steps the
// parser and walks command emission and flush. Depends on ice_pkg.
module ice_ctrl
    import ice_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_CMD_EMPTY,
        ST_CMD_RD,
        ST_CMD_EM,
        ST_FL_OPEN,
        ST_FL_PAY_RD,
        ST_FL_PAY_EM,
        ST_FL_CLOSE,
        ST_FL_END,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] open_lim;

    assign s_tready = (state_reg == ST_IDLE);
    assign open_lim = (stat.mode == MODE_OPEN) ? IDX_W'(stat.mc) : IDX_W'(stat.olen);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = KIND_TEXT;
        cmd.emit_src  = SRC_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (stat.in_flush)
                    begin
                        cmd.snap   = 1'b1;
                        state_next = (stat.mode == MODE_TEXT) ? ST_FL_END : ST_FL_OPEN;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if (stat.npend_zero)
                    state_next = ST_FINISH;
                else if (stat.can_emit)
                begin
                    cmd.step = 1'b1;
                    if (stat.step_cmd)
                        state_next = stat.pay_empty ? ST_CMD_EMPTY : ST_CMD_RD;
                end
            end
            ST_CMD_EMPTY:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_EMPTY;
                    cmd.emit_src  = SRC_NONE;
                    state_next    = ST_STEP;
                end
            end
            ST_CMD_RD:
            begin
                if (stat.idx == IDX_W'(stat.snap_cnt))
                    state_next = ST_STEP;
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_CMD_EM;
                end
            end
            ST_CMD_EM:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_CMD;
                    cmd.emit_src  = SRC_PAYLOAD;
                    cmd.idx_inc   = 1'b1;
                    state_next    = ST_CMD_RD;
                end
            end
            ST_FL_OPEN:
            begin
                if (stat.idx == open_lim)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = (stat.mode == MODE_OPEN) ? ST_FL_END : ST_FL_PAY_RD;
                end
                else if (stat.can_emit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_TEXT;
                    cmd.emit_src  = SRC_OPEN_LANE;
                    cmd.idx_inc   = 1'b1;
                end
            end
            ST_FL_PAY_RD:
            begin
                if (stat.idx == IDX_W'(stat.snap_cnt))
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = (stat.mode == MODE_CLOSE) ? ST_FL_CLOSE : ST_FL_END;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_FL_PAY_EM;
                end
            end
            ST_FL_PAY_EM:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_TEXT;
                    cmd.emit_src  = SRC_PAYLOAD;
                    cmd.idx_inc   = 1'b1;
                    state_next    = ST_FL_PAY_RD;
                end
            end
            ST_FL_CLOSE:
            begin
                if (stat.idx == IDX_W'(stat.mc))
                    state_next = ST_FL_END;
                else if (stat.can_emit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_TEXT;
                    cmd.emit_src  = SRC_CLOSE_LANE;
                    cmd.idx_inc   = 1'b1;
                end
            end
            ST_FL_END:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.stage_valid)
                    state_next = ST_IDLE;
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hdl/ice_datapath.sv
// Datapath of the inline command extractor: registers, parser step, rescan
// queue, payload buffer, result staging and output register. Uses ice_pkg.
module ice_datapath
    import ice_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [MARKER_W-1:0]   cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic [2:0]            m_tuser,
    output logic                  m_tlast,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    // configuration
    logic [MARKER_W-1:0] open_marker_reg, close_marker_reg;
    logic [LEN_W-1:0]    open_length_reg, close_length_reg;

    // parser state
    mode_t               mode_reg;
    logic [MC_W-1:0]     mc_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    snap_cnt_reg;
    logic                snap_ovf_reg;
    logic [IDX_W-1:0]    idx_reg;

    // rescan queue
    logic [7:0]            pend_reg [MARKER_MAX];
    logic [7:0]            pend_next [MARKER_MAX];
    logic [PEND_CNT_W-1:0] npend_reg, npend_next;

    // payload buffer
    logic [7:0] mem [PAYLOAD_DEPTH];
    logic [7:0] rd_data_reg;

    // staging and output
    logic       stage_valid_reg;
    kind_t      stage_kind_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_ovf_reg;
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_byte_reg;
    logic       out_ovf_reg;
    logic       out_last_reg;

    // step decode
    logic [LEN_W-1:0] olen, clen;
    logic [LEN_W-1:0] mc_inc;
    logic [7:0]       c;
    mode_t            nx_mode;
    logic [MC_W-1:0]  nx_mc;
    logic             start_pl, complete, step_emit, app_en, push_en, room;
    logic [7:0]       step_byte, app_byte;
    logic [MARKER_W-1:0] push_mk;

    logic       out_free, can_emit, emit_req, move;
    kind_t      new_kind;
    logic [7:0] new_byte;
    logic       new_ovf;

    assign cfg_ready = 1'b1;
    assign olen      = eff_len(open_length_reg);
    assign clen      = eff_len(close_length_reg);
    assign mc_inc    = LEN_W'(mc_reg) + LEN_W'(1);
    assign c         = pend_reg[0];
    assign room      = (cnt_reg < CNT_W'(PAYLOAD_DEPTH));

    always_comb
    begin
        nx_mode   = mode_reg;
        nx_mc     = mc_reg;
        start_pl  = 1'b0;
        complete  = 1'b0;
        step_emit = 1'b0;
        step_byte = c;
        app_en    = 1'b0;
        app_byte  = c;
        push_en   = 1'b0;
        push_mk   = open_marker_reg;
        unique case (mode_reg)
            MODE_TEXT:
            begin
                if (c == lane(open_marker_reg, 3'd0))
                begin
                    if (olen == LEN_W'(1))
                        start_pl = 1'b1;
                    else
                    begin
                        nx_mode = MODE_OPEN;
                        nx_mc   = MC_W'(1);
                    end
                end
                else
                    step_emit = 1'b1;
            end
            MODE_OPEN:
            begin
                if (c == lane(open_marker_reg, mc_reg))
                begin
                    if (mc_inc >= olen)
                        start_pl = 1'b1;
                    else
                        nx_mc = mc_reg + MC_W'(1);
                end
                else
                begin
                    // release first marker byte, rescan the rest
                    step_emit = 1'b1;
                    step_byte = lane(open_marker_reg, 3'd0);
                    nx_mode   = MODE_TEXT;
                    nx_mc     = '0;
                    push_en   = 1'b1;
                end
            end
            MODE_PAYLOAD:
            begin
                if (c == lane(close_marker_reg, 3'd0))
                begin
                    if (clen == LEN_W'(1))
                        complete = 1'b1;
                    else
                    begin
                        nx_mode = MODE_CLOSE;
                        nx_mc   = MC_W'(1);
                    end
                end
                else
                    app_en = 1'b1;
            end
            MODE_CLOSE:
            begin
                if (c == lane(close_marker_reg, mc_reg))
                begin
                    if (mc_inc >= clen)
                        complete = 1'b1;
                    else
                        nx_mc = mc_reg + MC_W'(1);
                end
                else
                begin
                    app_en   = 1'b1;
                    app_byte = lane(close_marker_reg, 3'd0);
                    nx_mode  = MODE_PAYLOAD;
                    nx_mc    = '0;
                    push_en  = 1'b1;
                    push_mk  = close_marker_reg;
                end
            end
        endcase
    end

    // pop the head; on a broken marker put held lanes 1..mc-1 and the byte in front
    always_comb
    begin
        logic [PEND_IDX_W-1:0] pidx;
        pidx = '0;
        for (int j = 0; j < MARKER_MAX; j++)
        begin
            pidx = PEND_IDX_W'(j - int'(mc_reg) + 1);
            if (push_en)
            begin
                if (j < int'(mc_reg) - 1)
                    pend_next[PEND_IDX_W'(j)] = lane(push_mk, 3'(j + 1));
                else if (j == int'(mc_reg) - 1)
                    pend_next[PEND_IDX_W'(j)] = c;
                else
                    pend_next[PEND_IDX_W'(j)] = pend_reg[pidx];
            end
            else if (j < MARKER_MAX - 1)
                pend_next[PEND_IDX_W'(j)] = pend_reg[PEND_IDX_W'(j + 1)];
            else
                pend_next[PEND_IDX_W'(j)] = pend_reg[PEND_IDX_W'(j)];
        end
        if (push_en)
            npend_next = npend_reg - PEND_CNT_W'(1) + PEND_CNT_W'(mc_reg);
        else
            npend_next = npend_reg - PEND_CNT_W'(1);
    end

    // result selection
    assign out_free = !out_valid_reg || m_tready;
    assign can_emit = !stage_valid_reg || out_free;
    assign emit_req = cmd.emit || (cmd.step && step_emit);
    assign move     = stage_valid_reg && (emit_req || (cmd.finish && out_free));

    always_comb
    begin
        if (cmd.step)
        begin
            new_kind = KIND_TEXT;
            new_byte = step_byte;
            new_ovf  = 1'b0;
        end
        else
        begin
            new_kind = cmd.emit_kind;
            new_ovf  = snap_ovf_reg;
            unique case (cmd.emit_src)
                SRC_OPEN_LANE:  new_byte = lane(open_marker_reg, idx_reg[2:0]);
                SRC_CLOSE_LANE: new_byte = lane(close_marker_reg, idx_reg[2:0]);
                SRC_PAYLOAD:    new_byte = rd_data_reg;
                SRC_NONE:       new_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_marker_reg  <= '0;
            open_length_reg  <= LEN_W'(1);
            close_marker_reg <= '0;
            close_length_reg <= LEN_W'(1);
            mode_reg         <= MODE_TEXT;
            mc_reg           <= '0;
            cnt_reg          <= '0;
            ovf_reg          <= 1'b0;
            snap_cnt_reg     <= '0;
            snap_ovf_reg     <= 1'b0;
            idx_reg          <= '0;
            npend_reg        <= '0;
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_OPEN_MARKER:  open_marker_reg  <= cfg_data;
                    REG_OPEN_LENGTH:  open_length_reg  <= cfg_data[LEN_W-1:0];
                    REG_CLOSE_MARKER: close_marker_reg <= cfg_data;
                    REG_CLOSE_LENGTH: close_length_reg <= cfg_data[LEN_W-1:0];
                endcase
            end

            if (cmd.load)
                npend_reg <= PEND_CNT_W'(1);
            else if (cmd.step)
                npend_reg <= npend_next;

            if (cmd.step)
            begin
                idx_reg <= '0;
                if (complete)
                begin
                    snap_cnt_reg <= cnt_reg;
                    snap_ovf_reg <= ovf_reg;
                    mode_reg     <= MODE_TEXT;
                    mc_reg       <= '0;
                    cnt_reg      <= '0;
                    ovf_reg      <= 1'b0;
                end
                else if (start_pl)
                begin
                    mode_reg <= MODE_PAYLOAD;
                    mc_reg   <= '0;
                    cnt_reg  <= '0;
                    ovf_reg  <= 1'b0;
                end
                else
                begin
                    mode_reg <= nx_mode;
                    mc_reg   <= nx_mc;
                    if (app_en)
                    begin
                        if (room)
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        else
                            ovf_reg <= 1'b1;
                    end
                end
            end
            else if (cmd.clear)
            begin
                mode_reg <= MODE_TEXT;
                mc_reg   <= '0;
                cnt_reg  <= '0;
                ovf_reg  <= 1'b0;
            end

            if (cmd.snap)
            begin
                snap_cnt_reg <= cnt_reg;
                snap_ovf_reg <= ovf_reg;
                idx_reg      <= '0;
            end
            else if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IDX_W'(1);

            if (emit_req)
                stage_valid_reg <= 1'b1;
            else if (cmd.finish && out_free)
                stage_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pend_reg[0] <= s_tdata;
        else if (cmd.step)
            pend_reg <= pend_next;

        if (cmd.step && app_en && !complete && !start_pl && room)
            mem[cnt_reg[ADDR_W-1:0]] <= app_byte;

        if (cmd.mem_rd)
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];

        if (emit_req)
        begin
            stage_kind_reg <= new_kind;
            stage_byte_reg <= new_byte;
            stage_ovf_reg  <= new_ovf;
        end

        if (move)
        begin
            out_kind_reg <= stage_kind_reg;
            out_byte_reg <= stage_byte_reg;
            out_ovf_reg  <= stage_ovf_reg;
            out_last_reg <= !emit_req;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_ovf_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        stat             = '0;
        stat.in_flush    = s_tuser[0];
        stat.can_emit    = can_emit;
        stat.out_free    = out_free;
        stat.stage_valid = stage_valid_reg;
        stat.npend_zero  = (npend_reg == '0);
        stat.step_cmd    = complete;
        stat.pay_empty   = (cnt_reg == '0);
        stat.mode        = mode_reg;
        stat.mc          = mc_reg;
        stat.olen        = olen;
        stat.snap_cnt    = snap_cnt_reg;
        stat.idx         = idx_reg;
    end

    // parser invariants and staging safety
    a_mc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_TEXT || mode_reg == MODE_PAYLOAD) |-> mc_reg == '0)
        else $error("match count set outside a marker");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(npend_reg) + int'(mc_reg)) <= MARKER_MAX)
        else $error("rescan queue plus held marker exceeds marker size");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> cnt_reg == CNT_W'(PAYLOAD_DEPTH))
        else $error("overflow flagged with room left in payload buffer");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit_req |-> can_emit)
        else $error("result produced with no free staging slot");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PAYLOAD_DEPTH))
        else $error("payload count beyond buffer depth");

endmodule

// File: hdl/inline_command_extractor_core.sv
// Top level of the inline command extractor: stream ports, config port,
// sequencer (ice_ctrl) and datapath (ice_datapath). Depends on ice_pkg.
//
// Byte-stream filter that splits plain text from inline commands. Each
// request is either a feed byte or a flush. Text bytes come out as kind 0.
// Bytes between the open marker and the close marker (each 1..8 bytes,
// first byte in the lowest lane of its register) are buffered, up to 32
// bytes, and on the close marker are sent as a run of kind 1 bytes, or as
// a single kind 2 result when nothing was between the markers. Payload
// beyond 32 bytes is dropped and every result of that command carries the
// overflow flag. When a marker breaks off partway its first byte is
// released and the remaining held bytes plus the new byte are rescanned
// one at a time. A flush hands any partial open marker, or the whole
// unterminated command (open marker, payload, partial close marker), back
// as text. tlast marks the final result of each request; a request that
// gives no result (a consumed marker byte, a flush in text mode) produces
// nothing on the output. Requests are taken one at a time: the port is
// ready again only once the previous request, its rescan steps included,
// is done. Command or flush replay of the payload buffer does a registered
// buffer read, then an emit, for each byte; replayed marker bytes are
// emitted straight from the marker registers. Results go through a
// one-deep staging register and an output register, so a new request is
// accepted while the last result still waits on m_tready.
// Configuration writes are always taken and must only be issued while the
// block is idle.
module inline_command_extractor_core
    import ice_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] func: 0 feed, 1 flush
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index, // 0 open marker, 1 open length,
                                             // 2 close marker, 3 close length
    input  logic [MARKER_W-1:0]   cfg_data,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic [2:0]            m_tuser,   // [1:0] kind, [2] overflowed
    output logic                  m_tlast    // last result of the request
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ice_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ice_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
